// ===== design/plist_pkg.sv =====
// Package for the positional list block: action codes, reset values and the
// packed item, result and control types shared by every module.
// No dependencies.
package plist_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam logic [2:0] ACT_INS_AT    = 3'd0;
    localparam logic [2:0] ACT_INS_FIRST = 3'd1;
    localparam logic [2:0] ACT_INS_LAST  = 3'd2;
    localparam logic [2:0] ACT_REM_AT    = 3'd3;
    localparam logic [2:0] ACT_REM_FIRST = 3'd4;
    localparam logic [2:0] ACT_REM_LAST  = 3'd5;

    localparam logic [6:0] CAP_IN_USE_RST = 7'd64;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] key;
        logic [6:0]         position;
    } item_t;

    typedef struct packed {
        logic               accepted;
        logic signed [31:0] removed_key;
        logic [6:0]         entry_total;
        logic               is_empty;
        logic               is_full;
    } result_t;

    // Operation that the cells carry out in this cycle.
    typedef struct packed {
        logic ins;
        logic rem;
    } op_t;

    // Outcome of the decode for the result item.
    typedef struct packed {
        logic accepted;
        logic empty;
        logic full;
    } status_t;

endpackage

// ===== design/plist_cell.sv =====
// One storage cell of the list: holds the entry at a fixed position and takes
// the inserted key or a neighbour's entry. Depends on plist_pkg.
module plist_cell #(
    parameter int IDX = 0,
    parameter int IW  = 6
) (
    input  logic               clk,
    input  plist_pkg::op_t     op,
    input  logic [IW-1:0]      pos,
    input  logic signed [31:0] key,
    input  logic signed [31:0] left,
    input  logic signed [31:0] right,
    output logic signed [31:0] value,
    output logic signed [31:0] tap
);
    import plist_pkg::*;

    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;
    logic               at_pos;
    logic               above_pos;

    assign at_pos    = (pos == IW'(IDX));
    assign above_pos = (pos < IW'(IDX));

    always_comb
    begin
        value_next = value_reg;
        if (op.ins && at_pos)
        begin
            value_next = key;
        end
        else if (op.ins && above_pos)
        begin
            value_next = left;
        end
        else if (op.rem && (at_pos || above_pos))
        begin
            value_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    // Only the cell at the target position shows its entry for a removal.
    assign tap   = (op.rem && at_pos) ? value_reg : 32'sd0;

endmodule

// ===== design/plist_ctrl.sv =====
// Decode of one operation: target position, acceptance, new count and status.
// Depends on plist_pkg.
module plist_ctrl #(
    parameter int CAPACITY = plist_pkg::CAPACITY_DEF,
    parameter int CW       = 7,
    parameter int IW       = 6
) (
    input  plist_pkg::item_t   item,
    input  logic [CW-1:0]      count,
    input  logic [6:0]         cap,
    output plist_pkg::op_t     op,
    output logic [IW-1:0]      pos,
    output logic [CW-1:0]      count_next,
    output plist_pkg::status_t status
);
    import plist_pkg::*;

    localparam int W = ((CW > 7) ? CW : 7) + 1;

    logic [W-1:0] count_w;
    logic [W-1:0] cap_eff;
    logic [W-1:0] tpos;
    logic [W-1:0] new_count;
    logic         ins_req;
    logic         rem_req;
    logic         ins_ok;
    logic         rem_ok;

    assign count_w = W'(count);
    assign cap_eff = (W'(cap) < W'(CAPACITY)) ? W'(cap) : W'(CAPACITY);

    always_comb
    begin
        ins_req = 1'b0;
        rem_req = 1'b0;
        tpos    = '0;
        case (item.action)
            ACT_INS_AT:
            begin
                ins_req = 1'b1;
                tpos    = W'(item.position);
            end
            ACT_INS_FIRST:
            begin
                ins_req = 1'b1;
            end
            ACT_INS_LAST:
            begin
                ins_req = 1'b1;
                tpos    = count_w;
            end
            ACT_REM_AT:
            begin
                rem_req = 1'b1;
                tpos    = W'(item.position);
            end
            ACT_REM_FIRST:
            begin
                rem_req = 1'b1;
            end
            ACT_REM_LAST:
            begin
                rem_req = 1'b1;
                tpos    = count_w - W'(1);
            end
            default:
            begin
                ins_req = 1'b0;
            end
        endcase
    end

    assign ins_ok = ins_req && (count_w < cap_eff) && (tpos <= count_w);
    assign rem_ok = rem_req && (count_w != '0) && (tpos < count_w);

    always_comb
    begin
        new_count = count_w;
        if (ins_ok)
        begin
            new_count = count_w + W'(1);
        end
        else if (rem_ok)
        begin
            new_count = count_w - W'(1);
        end
    end

    assign op.ins          = ins_ok;
    assign op.rem          = rem_ok;
    assign pos             = tpos[IW-1:0];
    assign count_next      = new_count[CW-1:0];
    assign status.accepted = ins_ok || rem_ok;
    assign status.empty    = (new_count == '0);
    assign status.full     = (new_count >= cap_eff);

endmodule

// ===== design/positional_list_insert_remove_top.sv =====
// Positional list of signed 32-bit keys, one storage cell per position.
// Each result is registered and appears in the cycle after its item transfer.
// Throughput: one item per cycle while no held result is stalled; every cell
// shifts in parallel, so the decode and the shift together set the rate.
// Reset: asynchronous, active low; clears the count and the output valid and
// sets the capacity in use to 64. The cells are not cleared.
module positional_list_insert_remove_top #(
    parameter int CAPACITY = plist_pkg::CAPACITY_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  plist_pkg::item_t   item,
    output logic               result_valid,
    input  logic               result_stall,
    output plist_pkg::result_t result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [6:0]         cfg_data
);
    import plist_pkg::*;

    // Count width holds the full capacity; index width addresses one cell.
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [6:0]         cap_reg;
    logic               result_valid_reg;
    logic               result_valid_next;
    result_t            result_reg;
    result_t            result_next;

    logic               xfer;
    op_t                dec_op;
    op_t                cell_op;
    logic [IW-1:0]      dec_pos;
    logic [CW-1:0]      dec_count;
    status_t            dec_status;
    logic signed [31:0] cell_value [CAPACITY];
    logic signed [31:0] cell_tap [CAPACITY];
    logic signed [31:0] taken;

    // The output register parts the two sides: a new item is taken unless a
    // finished result is still held and the consumer is stalling.
    assign item_stall = result_valid_reg && result_stall;
    assign xfer       = item_valid && !item_stall;
    assign cfg_ready  = 1'b1;

    plist_ctrl #(
        .CAPACITY (CAPACITY),
        .CW       (CW),
        .IW       (IW)
    ) u_ctrl (
        .item       (item),
        .count      (count_reg),
        .cap        (cap_reg),
        .op         (dec_op),
        .pos        (dec_pos),
        .count_next (dec_count),
        .status     (dec_status)
    );

    // Cells only act on an item transfer.
    assign cell_op.ins = dec_op.ins && xfer;
    assign cell_op.rem = dec_op.rem && xfer;

    // The row of cells. Each cell sees its left and right neighbour; the ends
    // of the row are fed with zero, which no accepted operation ever keeps.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [31:0] left_val;
        logic signed [31:0] right_val;

        if (i == 0)
        begin : g_first
            assign left_val = 32'sd0;
        end
        else
        begin : g_mid_l
            assign left_val = cell_value[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_val = 32'sd0;
        end
        else
        begin : g_mid_r
            assign right_val = cell_value[i+1];
        end

        plist_cell #(
            .IDX (i),
            .IW  (IW)
        ) u_cell (
            .clk   (clk),
            .op    (cell_op),
            .pos   (dec_pos),
            .key   (item.key),
            .left  (left_val),
            .right (right_val),
            .value (cell_value[i]),
            .tap   (cell_tap[i])
        );
    end

    // At most one cell drives a non-zero tap, so an OR across the row gives
    // the removed key, or zero when nothing is removed.
    always_comb
    begin
        taken = 32'sd0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            taken = taken | cell_tap[i];
        end
    end

    always_comb
    begin
        count_next        = count_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        if (xfer)
        begin
            count_next               = dec_count;
            result_valid_next        = 1'b1;
            result_next.accepted     = dec_status.accepted;
            result_next.removed_key  = taken;
            result_next.entry_total  = 7'(dec_count);
            result_next.is_empty     = dec_status.empty;
            result_next.is_full      = dec_status.full;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            cap_reg          <= CAP_IN_USE_RST;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    // The result payload needs no reset; it is qualified by the valid.
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== design/plist_checker.sv =====
// Port-level checks for the positional list block, bound to the top level.
// Depends on plist_pkg and positional_list_insert_remove_top.
module plist_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_stall,
    input logic               result_valid,
    input logic               result_stall,
    input plist_pkg::result_t result
);
    import plist_pkg::*;

    // A held result stays put while the consumer stalls.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // Every item transfer yields a result in the next cycle.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> result_valid)
        else $error("no result after item transfer");

    // A refused operation reports a zero key.
    a_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.accepted |-> result.removed_key == 32'sd0)
        else $error("refused operation reported a key");

    // An empty list reports a zero total.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.is_empty |-> result.entry_total == 7'd0)
        else $error("empty list with non-zero total");

endmodule

bind positional_list_insert_remove_top plist_checker u_plist_checker (.*);

// ===== tb/positional_list_insert_remove_top_tb.sv =====
// Self-checking testbench for positional_list_insert_remove_top: directed table, then random
// phases under several idling patterns and capacity settings, checked against a shadow list or typed-in results.
// Depends on plist_pkg and the positional_list_insert_remove_top module only.
module positional_list_insert_remove_top_tb;

    import plist_pkg::*;

    // Action codes that the block decodes as no operation.
    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int          MAX_REPORTS = 10;
    localparam int          DIRECTED_ROWS = 25;
    localparam int          PHASES = 8;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_e;

    // One row of the directed table: either a capacity write or an item transfer.
    // When has_fixed is set, the result is typed in by hand and replaces the
    // shadow list's answer as the expectation; the shadow list still advances.
    typedef struct packed {
        logic       is_cfg;
        logic [6:0] cap;
        item_t      stim;
        logic       has_fixed;
        result_t    fixed;
    } directed_row_t;

    localparam result_t NO_RES = '0;
    localparam item_t   NO_ITEM = '0;

    // The list starts empty with the capacity at its reset value of 64.
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        // Every kind of removal on an empty list is refused.
        '{1'b0, 7'd0, '{ACT_REM_FIRST, 32'sd0, 7'd0}, 1'b1, '{1'b0, 32'sd0, 7'd0, 1'b1, 1'b0}},
        '{1'b0, 7'd0, '{ACT_REM_LAST, 32'sd0, 7'd0}, 1'b1, '{1'b0, 32'sd0, 7'd0, 1'b1, 1'b0}},
        '{1'b0, 7'd0, '{ACT_REM_AT, 32'sd0, 7'd0}, 1'b1, '{1'b0, 32'sd0, 7'd0, 1'b1, 1'b0}},
        // A spare action code changes nothing but still reports status.
        '{1'b0, 7'd0, '{ACT_SPARE_6, 32'sd0, 7'd0}, 1'b1, '{1'b0, 32'sd0, 7'd0, 1'b1, 1'b0}},
        // Insert past the count is refused.
        '{1'b0, 7'd0, '{ACT_INS_AT, 32'sd9, 7'd1}, 1'b1, '{1'b0, 32'sd0, 7'd0, 1'b1, 1'b0}},
        // Key extremes go in at the front and at the end.
        '{1'b0, 7'd0, '{ACT_INS_FIRST, 32'sh7FFFFFFF, 7'd0}, 1'b1,
          '{1'b1, 32'sd0, 7'd1, 1'b0, 1'b0}},
        '{1'b0, 7'd0, '{ACT_INS_LAST, 32'sh80000000, 7'd0}, 1'b1,
          '{1'b1, 32'sd0, 7'd2, 1'b0, 1'b0}},
        '{1'b0, 7'd0, '{ACT_INS_AT, 32'shFFFFFFFF, 7'd1}, 1'b0, NO_RES},
        // Insert exactly at the count appends.
        '{1'b0, 7'd0, '{ACT_INS_AT, 32'sd0, 7'd3}, 1'b0, NO_RES},
        '{1'b0, 7'd0, '{ACT_INS_AT, 32'sd5, 7'd127}, 1'b1, '{1'b0, 32'sd0, 7'd4, 1'b0, 1'b0}},
        // Removal at or beyond the count is refused; then the list is drained.
        '{1'b0, 7'd0, '{ACT_REM_AT, 32'sd0, 7'd4}, 1'b1, '{1'b0, 32'sd0, 7'd4, 1'b0, 1'b0}},
        '{1'b0, 7'd0, '{ACT_REM_AT, 32'sd0, 7'd127}, 1'b1, '{1'b0, 32'sd0, 7'd4, 1'b0, 1'b0}},
        '{1'b0, 7'd0, '{ACT_SPARE_7, 32'shFFFFFFFF, 7'd127}, 1'b1,
          '{1'b0, 32'sd0, 7'd4, 1'b0, 1'b0}},
        '{1'b0, 7'd0, '{ACT_REM_AT, 32'sd0, 7'd1}, 1'b0, NO_RES},
        '{1'b0, 7'd0, '{ACT_REM_LAST, 32'sd0, 7'd0}, 1'b0, NO_RES},
        '{1'b0, 7'd0, '{ACT_REM_FIRST, 32'sd0, 7'd0}, 1'b1,
          '{1'b1, 32'sh7FFFFFFF, 7'd1, 1'b0, 1'b0}},
        '{1'b0, 7'd0, '{ACT_REM_AT, 32'sd0, 7'd0}, 1'b1,
          '{1'b1, 32'sh80000000, 7'd0, 1'b1, 1'b0}},
        // Capacity of one: a single entry fills the list.
        '{1'b1, 7'd1, NO_ITEM, 1'b0, NO_RES},
        '{1'b0, 7'd0, '{ACT_INS_LAST, 32'sh5A5A5A5A, 7'd0}, 1'b0, NO_RES},
        '{1'b0, 7'd0, '{ACT_INS_FIRST, 32'sd1, 7'd0}, 1'b1, '{1'b0, 32'sd0, 7'd1, 1'b0, 1'b1}},
        // Capacity of zero below the count: removal still works, list reads full.
        '{1'b1, 7'd0, NO_ITEM, 1'b0, NO_RES},
        '{1'b0, 7'd0, '{ACT_REM_FIRST, 32'sd0, 7'd0}, 1'b1,
          '{1'b1, 32'sh5A5A5A5A, 7'd0, 1'b1, 1'b1}},
        '{1'b0, 7'd0, '{ACT_INS_FIRST, 32'sd2, 7'd0}, 1'b1, '{1'b0, 32'sd0, 7'd0, 1'b1, 1'b1}},
        // Capacity above the built size is clamped.
        '{1'b1, 7'd127, NO_ITEM, 1'b0, NO_RES},
        '{1'b0, 7'd0, '{ACT_INS_AT, 32'sh12345678, 7'd0}, 1'b0, NO_RES}
    };

    // Random phases: capacity setting, idling pattern and number of items.
    localparam logic [6:0] PHASE_CAP [PHASES] = '{
        CAP_IN_USE_RST, 7'd127, 7'd1, 7'd0, 7'd10, 7'd37, CAP_IN_USE_RST, CAP_IN_USE_RST
    };
    localparam idle_mode_e PHASE_IDLE [PHASES] = '{
        IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
        IDLE_BOTH, IDLE_RECEIVER, IDLE_SENDER, IDLE_NONE
    };
    localparam int PHASE_ITEMS [PHASES] = '{250, 250, 150, 100, 200, 200, 250, 250};

    // Insert bias per stretch of 60 items: fill the list, drain it, then mix.
    localparam int STRETCH = 60;
    localparam int INSERT_BIAS [3] = '{85, 15, 50};

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       item_valid = 1'b0;
    logic       item_stall;
    item_t      item = '0;
    logic       result_valid;
    logic       result_stall = 1'b0;
    result_t    result;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [6:0] cfg_data = '0;

    // Shadow copy of the list, its count and the capacity register.
    logic signed [31:0] shadow_keys [CAPACITY_DEF];
    int                 shadow_count = 0;
    int                 shadow_cap = int'(CAP_IN_USE_RST);

    result_t     expected_results [$];
    result_t     oldest_result;
    int          fail_count = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int unsigned cycle_count = 0;

    positional_list_insert_remove_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Applies one accepted item to the shadow list and returns the result the
    // block should give for it. Only entries below the count are ever read.
    function automatic result_t apply_to_shadow(item_t it);
        result_t answer;
        int      limit;
        int      slot;
        logic    is_ins;
        logic    is_rem;
        answer = '0;
        limit  = shadow_cap < CAPACITY_DEF ? shadow_cap : CAPACITY_DEF;
        slot   = 0;
        is_ins = 1'b0;
        is_rem = 1'b0;
        case (it.action)
            ACT_INS_AT:    begin is_ins = 1'b1; slot = int'(it.position); end
            ACT_INS_FIRST: begin is_ins = 1'b1; slot = 0; end
            ACT_INS_LAST:  begin is_ins = 1'b1; slot = shadow_count; end
            ACT_REM_AT:    begin is_rem = 1'b1; slot = int'(it.position); end
            ACT_REM_FIRST: begin is_rem = 1'b1; slot = 0; end
            ACT_REM_LAST:  begin is_rem = 1'b1; slot = shadow_count - 1; end
            default:       ;
        endcase
        if (is_ins && shadow_count < limit && slot <= shadow_count)
        begin
            for (int i = shadow_count; i > slot; i--)
                shadow_keys[i] = shadow_keys[i - 1];
            shadow_keys[slot] = it.key;
            shadow_count++;
            answer.accepted = 1'b1;
        end
        if (is_rem && shadow_count > 0 && slot >= 0 && slot < shadow_count)
        begin
            answer.removed_key = shadow_keys[slot];
            for (int i = slot; i + 1 < shadow_count; i++)
                shadow_keys[i] = shadow_keys[i + 1];
            shadow_count--;
            answer.accepted = 1'b1;
        end
        answer.entry_total = shadow_count[6:0];
        answer.is_empty    = (shadow_count == 0);
        answer.is_full     = (shadow_count >= limit);
        return answer;
    endfunction

    // Random item, mostly well formed against the current count so that the
    // list really fills and drains; a few spare codes and wild positions.
    function automatic item_t random_item(int insert_pct);
        item_t it;
        int    roll;
        roll = $urandom_range(99);
        if (roll < 3)
            it.action = $urandom_range(0, 1) ? ACT_SPARE_6 : ACT_SPARE_7;
        else if ($urandom_range(99) < insert_pct)
            it.action = 3'($urandom_range(ACT_INS_AT, ACT_INS_LAST));
        else
            it.action = 3'($urandom_range(ACT_REM_AT, ACT_REM_LAST));
        case ($urandom_range(0, 19))
            0:       it.key = 32'sh7FFFFFFF;
            1:       it.key = 32'sh80000000;
            2:       it.key = 32'sd0;
            3:       it.key = 32'shFFFFFFFF;
            default: it.key = $urandom;
        endcase
        if ($urandom_range(99) < 15)
            it.position = 7'($urandom_range(0, 127));
        else if (it.action == ACT_REM_AT)
            it.position = (shadow_count == 0) ? 7'd0 :
                          7'($urandom_range(0, shadow_count - 1));
        else
            it.position = 7'($urandom_range(0, shadow_count));
        return it;
    endfunction

    task automatic flag_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // Offers one item, with random idle cycles before it, and records what it
    // should produce once the transfer happens. Valid stays high while stalled.
    task automatic send_item(input item_t it, input logic has_fixed, input result_t fixed);
        result_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
        predicted = apply_to_shadow(it);
        expected_results.push_back(has_fixed ? fixed : predicted);
    endtask

    // Stops offering items until every outstanding result has been taken.
    task automatic wait_for_results();
        item_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Writes the capacity register; the caller makes sure the block is idle.
    task automatic program_capacity(input logic [6:0] cap);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        shadow_cap = int'(cap);
    endtask

    task automatic set_idling(input idle_mode_e mode);
        case (mode)
            IDLE_SENDER:   begin send_idle_pct = 70; stall_pct = 0; end
            IDLE_RECEIVER: begin send_idle_pct = 0; stall_pct = 70; end
            IDLE_BOTH:     begin send_idle_pct = 6; stall_pct = 6; end
            default:       begin send_idle_pct = 0; stall_pct = 0; end
        endcase
    endtask

    // Result side: every transfer is checked against the oldest expectation,
    // and the stall for the next edge is drawn after the check, so the check
    // always sees the stall value that the block saw at this edge.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                flag_failure($sformatf("result transfer with nothing expected: %p", result));
            end
            else
            begin
                oldest_result = expected_results.pop_front();
                if (result.accepted !== oldest_result.accepted ||
                    result.removed_key !== oldest_result.removed_key ||
                    result.entry_total !== oldest_result.entry_total ||
                    result.is_empty !== oldest_result.is_empty ||
                    result.is_full !== oldest_result.is_full)
                    flag_failure($sformatf("result mismatch: expected %p, got %p",
                                           oldest_result, result));
            end
        end
        result_stall <= ($urandom_range(99) < stall_pct);
    end

    // A run that hangs ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int insert_pct;
        insert_pct = 50;
        for (int i = 0; i < CAPACITY_DEF; i++)
            shadow_keys[i] = '0;

        rst_n <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, walked row by row; capacity writes wait for the
        // block to go idle first.
        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            if (DIRECTED[r].is_cfg)
            begin
                wait_for_results();
                program_capacity(DIRECTED[r].cap);
            end
            else
            begin
                send_item(DIRECTED[r].stim, DIRECTED[r].has_fixed, DIRECTED[r].fixed);
            end
        end

        // Random phases. Halfway through each one the sender holds off until
        // all results are home, which also puts an empty pipeline mid-phase.
        for (int p = 0; p < PHASES; p++)
        begin
            wait_for_results();
            program_capacity(PHASE_CAP[p]);
            set_idling(PHASE_IDLE[p]);
            for (int n = 0; n < PHASE_ITEMS[p]; n++)
            begin
                if (n % STRETCH == 0)
                    insert_pct = INSERT_BIAS[(n / STRETCH) % 3];
                if (n == PHASE_ITEMS[p] / 2)
                    wait_for_results();
                send_item(random_item(insert_pct), 1'b0, NO_RES);
            end
        end

        wait_for_results();
        // The block answers in the cycle after a transfer; the extra wait
        // below catches any stray result.
        repeat (4) @(posedge clk);

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
design/plist_pkg.sv
design/plist_cell.sv
design/plist_ctrl.sv
design/positional_list_insert_remove_top.sv
design/plist_checker.sv
tb/positional_list_insert_remove_top_tb.sv
